>>> rtl/arrt_pkg.sv
// ----------------------------------------------------------------------------
// arrt_pkg: shared types and constants
// Field widths, codes and table sizing for the range transition recorder.
// ----------------------------------------------------------------------------
package arrt_pkg;

   localparam int RANGES  = 8;
   localparam int IDX_W   = (RANGES > 1) ? $clog2(RANGES) : 1;
   localparam int USED_W  = $clog2(RANGES + 1);

   localparam int ADDR_W  = 64;
   localparam int SIZE_W  = 32;
   localparam int COUNT_W = 32;
   localparam int KIND_W  = 2;
   localparam int CLS_W   = 2;
   localparam int MODE_W  = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_EVENT = 2'd0,
      KIND_ADD   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_FLUSH = 2'd3
   } kind_type;

   typedef enum logic [CLS_W-1:0] {
      CLS_NONE = 2'd0,
      CLS_IN   = 2'd1,
      CLS_OUT  = 2'd2
   } cls_type;

   localparam logic [MODE_W-1:0] MODE_INBOUND  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OUTBOUND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BOTH     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BOTH_ALT = 2'd3;  // undefined code, acts as both
   localparam logic [MODE_W-1:0] MODE_RESET    = MODE_BOTH;

   localparam logic STATUS_RECORD = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // table update request from the transition logic
   typedef struct packed {
      logic              add_en;
      logic              clear_en;
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
   } table_ctrl_type;

   typedef struct packed {
      logic hit;
      logic full;
   } table_stat_type;

endpackage

>>> rtl/arrt_channels.sv
// ----------------------------------------------------------------------------
// arrt channels: request and response handshake interfaces
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface arrt_req_if;
   import arrt_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ADDR_W-1:0] address;
   logic [SIZE_W-1:0] range_size;

   modport source (output valid, kind, address, range_size, input ready);
   modport sink   (input valid, kind, address, range_size, output ready);
endinterface

interface arrt_rsp_if;
   import arrt_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic [ADDR_W-1:0]  record_address;
   logic [CLS_W-1:0]   record_class;
   logic [COUNT_W-1:0] record_count;

   modport source (output valid, status, record_address, record_class, record_count,
                   input ready);
   modport sink   (input valid, status, record_address, record_class, record_count,
                   output ready);
endinterface

>>> rtl/arrt_range_table.sv
// ----------------------------------------------------------------------------
// arrt_range_table: address range table with parallel match
// Holds start/end pairs, appends on add, empties on clear, and reports
// whether an address falls in any loaded range (end inclusive).
// ----------------------------------------------------------------------------
module arrt_range_table (
   input  logic                     clock,
   input  logic                     reset,
   input  arrt_pkg::table_ctrl_type ctrl,
   input  logic [arrt_pkg::ADDR_W-1:0] lookup_address,
   output arrt_pkg::table_stat_type stat
);
   import arrt_pkg::*;

   logic [ADDR_W-1:0] start_ff [RANGES];
   logic [ADDR_W-1:0] end_ff   [RANGES];
   logic [USED_W-1:0] used_ff, used_in;
   logic [RANGES-1:0] match;

   always_comb begin
      used_in = used_ff;
      if (ctrl.clear_en) begin
         used_in = '0;
      end else if (ctrl.add_en) begin
         used_in = used_ff + USED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // end wraps modulo 2^64; a wrapped range then matches nothing
   always_ff @(posedge clock) begin
      if (ctrl.add_en) begin
         start_ff[used_ff[IDX_W-1:0]] <= ctrl.start;
         end_ff[used_ff[IDX_W-1:0]]   <= ctrl.start + ADDR_W'(ctrl.size);
      end
   end

   always_comb begin
      for (int i = 0; i < RANGES; i++) begin
         match[i] = (USED_W'(i) < used_ff) &&
                    (lookup_address >= start_ff[i]) &&
                    (lookup_address <= end_ff[i]);
      end
   end

   assign stat.hit  = |match;
   assign stat.full = (used_ff == USED_W'(RANGES));

endmodule

>>> rtl/address_range_transition_recorder_unit.sv
// A transaction is registered on acceptance and its record, if any, passes through
//    the result register before it is presented on rsp_ch.
// Throughput: one transaction per cycle unless rsp_ch stalls; range compares run
//    in parallel; class logic is combinational between input and result register.
// Reset: synchronous, active high; empties the range table, clears class and
//    pending record, sets the capture mode to both. No clearing pass.
// ----------------------------------------------------------------------------
// address_range_transition_recorder_unit: top level
// Classifies event addresses against the range table and records class changes.
// ----------------------------------------------------------------------------
module address_range_transition_recorder_unit (
   input  logic                        clock,
   input  logic                        reset,
   arrt_req_if.sink                    req_ch,
   arrt_rsp_if.source                  rsp_ch,
   input  logic                        csr_write_enable,
   input  logic [arrt_pkg::MODE_W-1:0] csr_write_data
);
   import arrt_pkg::*;

   // input register
   logic              s1_valid_ff;
   kind_type          s1_kind_ff;
   logic [ADDR_W-1:0] s1_address_ff;
   logic [SIZE_W-1:0] s1_size_ff;

   // recorder state
   logic [MODE_W-1:0]  mode_ff;
   cls_type            current_ff, current_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]  pend_address_ff, pend_address_in;
   logic [COUNT_W-1:0] pend_count_ff, pend_count_in;
   cls_type            pend_class_ff, pend_class_in;

   // result register
   logic               out_valid_ff;
   logic               out_status_ff, out_status_in;
   logic [ADDR_W-1:0]  out_address_ff, out_address_in;
   cls_type            out_class_ff, out_class_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic           advance;
   logic           process;
   logic           emit;
   cls_type        cls;
   cls_type        want;
   table_ctrl_type tctrl;
   table_stat_type tstat;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign process      = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;

   arrt_range_table u_table (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (tctrl),
      .lookup_address (s1_address_ff),
      .stat           (tstat)
   );

   assign cls  = tstat.hit ? CLS_IN : CLS_OUT;
   assign want = (mode_ff == MODE_INBOUND) ? CLS_IN : CLS_OUT;

   always_comb begin
      emit            = 1'b0;
      out_status_in   = STATUS_RECORD;
      out_address_in  = '0;
      out_class_in    = CLS_NONE;
      out_count_in    = '0;
      current_in      = current_ff;
      pend_valid_in   = pend_valid_ff;
      pend_address_in = pend_address_ff;
      pend_count_in   = pend_count_ff;
      pend_class_in   = pend_class_ff;
      tctrl.add_en    = 1'b0;
      tctrl.clear_en  = 1'b0;
      tctrl.start     = s1_address_ff;
      tctrl.size      = s1_size_ff;

      case (s1_kind_ff)
         KIND_ADD: begin
            if (s1_address_ff == '0 || s1_size_ff == '0 || tstat.full) begin
               emit          = 1'b1;
               out_status_in = STATUS_REJECT;
            end else begin
               tctrl.add_en = process;
            end
         end
         KIND_CLEAR: begin
            tctrl.clear_en = process;
         end
         KIND_FLUSH: begin
            if (pend_valid_ff) begin
               emit           = 1'b1;
               out_address_in = pend_address_ff;
               out_class_in   = pend_class_ff;
               out_count_in   = pend_count_ff;
               pend_valid_in  = 1'b0;
            end
         end
         KIND_EVENT: begin
            if (cls != current_ff) begin
               current_in = cls;
               if (mode_ff inside {MODE_BOTH, MODE_BOTH_ALT}) begin
                  emit           = 1'b1;
                  out_address_in = s1_address_ff;
                  out_class_in   = cls;
               end else if (cls == want) begin
                  if (pend_valid_ff && pend_address_ff == s1_address_ff) begin
                     if (pend_count_ff != COUNT_MAX) begin
                        pend_count_in = pend_count_ff + COUNT_W'(1);
                     end
                  end else begin
                     if (pend_valid_ff) begin
                        emit           = 1'b1;
                        out_address_in = pend_address_ff;
                        out_class_in   = pend_class_ff;
                        out_count_in   = pend_count_ff;
                     end
                     pend_valid_in   = 1'b1;
                     pend_address_in = s1_address_ff;
                     pend_count_in   = COUNT_W'(1);
                     pend_class_in   = cls;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         mode_ff       <= MODE_RESET;
         current_ff    <= CLS_NONE;
         pend_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff && emit;
         end
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         if (process) begin
            current_ff    <= current_in;
            pend_valid_ff <= pend_valid_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_kind_ff    <= kind_type'(req_ch.kind);
         s1_address_ff <= req_ch.address;
         s1_size_ff    <= req_ch.range_size;
      end
      if (process) begin
         pend_address_ff <= pend_address_in;
         pend_count_ff   <= pend_count_in;
         pend_class_ff   <= pend_class_in;
      end
      if (process && emit) begin
         out_status_ff  <= out_status_in;
         out_address_ff <= out_address_in;
         out_class_ff   <= out_class_in;
         out_count_ff   <= out_count_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_status_ff;
   assign rsp_ch.record_address = out_address_ff;
   assign rsp_ch.record_class   = out_class_ff;
   assign rsp_ch.record_count   = out_count_ff;

endmodule

>>> tb/sv/address_range_transition_recorder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// address_range_transition_recorder_unit_tb: self-checking testbench
// Loads range tables, sends address events, adds, clears and flushes, and
// checks every record against a cycle-free model of the recorder. Record mode
// is changed between phases. Both handshake sides idle at random, and the
// response side also holds off for one long stretch.
// ----------------------------------------------------------------------------
module address_range_transition_recorder_unit_tb;
   import arrt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 210;
   localparam logic [MODE_W-1:0] PHASE_MODE [PHASES] = '{
      MODE_OUTBOUND, MODE_BOTH_ALT, MODE_INBOUND, MODE_BOTH, MODE_OUTBOUND, MODE_INBOUND
   };

   typedef struct packed {
      logic               status;
      logic [ADDR_W-1:0]  addr;
      cls_type            cls;
      logic [COUNT_W-1:0] count;
   } record_type;

   // Tracks table, class and pending record; queues the records the block owes.
   class transition_tracker;
      logic [ADDR_W-1:0]  range_lo [RANGES];
      logic [ADDR_W-1:0]  range_hi [RANGES];
      int unsigned        used;
      cls_type            cur_class;
      logic               pend_valid;
      logic [ADDR_W-1:0]  pend_addr;
      logic [COUNT_W-1:0] pend_count;
      cls_type            pend_class;
      logic [MODE_W-1:0]  mode;
      record_type         record_queue [$];
      int unsigned        error_count;

      function new();
         used        = 0;
         cur_class   = CLS_NONE;
         pend_valid  = 1'b0;
         pend_addr   = '0;
         pend_count  = '0;
         pend_class  = CLS_NONE;
         mode        = MODE_RESET;
         error_count = 0;
      endfunction

      function void queue_record(logic st, logic [ADDR_W-1:0] a, cls_type c,
                                 logic [COUNT_W-1:0] n);
         record_type r;
         r.status = st;
         r.addr   = a;
         r.cls    = c;
         r.count  = n;
         record_queue.push_back(r);
      endfunction

      function void note_item(kind_type k, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
         cls_type c;
         case (k)
            KIND_ADD: begin
               if (a == '0 || s == '0 || used >= RANGES) begin
                  queue_record(STATUS_REJECT, '0, CLS_NONE, '0);
               end else begin
                  range_lo[used] = a;
                  range_hi[used] = a + {{(ADDR_W-SIZE_W){1'b0}}, s};
                  used++;
               end
            end
            KIND_CLEAR: used = 0;
            KIND_FLUSH: begin
               if (pend_valid) begin
                  queue_record(STATUS_RECORD, pend_addr, pend_class, pend_count);
                  pend_valid = 1'b0;
                  pend_addr  = '0;
                  pend_count = '0;
                  pend_class = CLS_NONE;
               end
            end
            KIND_EVENT: begin
               c = CLS_OUT;
               for (int i = 0; i < used; i++)
                  if (a >= range_lo[i] && a <= range_hi[i]) c = CLS_IN;
               if (c != cur_class) begin
                  cur_class = c;
                  if (mode == MODE_BOTH || mode == MODE_BOTH_ALT) begin
                     queue_record(STATUS_RECORD, a, c, '0);
                  end else if ((mode == MODE_INBOUND && c == CLS_IN) ||
                               (mode == MODE_OUTBOUND && c == CLS_OUT)) begin
                     if (pend_valid && pend_addr == a) begin
                        if (pend_count != COUNT_MAX) pend_count++;
                     end else begin
                        if (pend_valid)
                           queue_record(STATUS_RECORD, pend_addr, pend_class, pend_count);
                        pend_valid = 1'b1;
                        pend_addr  = a;
                        pend_count = 1;
                        pend_class = c;
                     end
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            error_count++;
         end
      endfunction

      function void check_record(record_type got);
         record_type want;
         if (record_queue.size() == 0) begin
            $display("%0t: unexpected record, expected none, actual %h", $time, got);
            error_count++;
            return;
         end
         want = record_queue.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("record_address", want.addr, got.addr);
         compare_field("record_class", want.cls, got.cls);
         compare_field("record_count", want.count, got.count);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                csr_write_enable;
   logic [MODE_W-1:0]   csr_write_data;

   arrt_req_if req_ch ();
   arrt_rsp_if rsp_ch ();

   transition_tracker tracker;
   int unsigned       req_idle_pct;
   int unsigned       rsp_idle_pct;
   int unsigned       hold_left;
   int unsigned       items_sent;
   int unsigned       cycle_count;
   logic [ADDR_W-1:0] addr_pool [4];

   address_range_transition_recorder_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("address_range_transition_recorder_unit test failed");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off when requested
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_record('{rsp_ch.status, rsp_ch.record_address,
                                   cls_type'(rsp_ch.record_class), rsp_ch.record_count});
         if (req_ch.valid && req_ch.ready)
            tracker.note_item(kind_type'(req_ch.kind), req_ch.address, req_ch.range_size);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(kind_type k, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= k;
      req_ch.address    <= a;
      req_ch.range_size <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // stop offering and wait until every owed record is in, plus latency margin
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.record_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(logic [MODE_W-1:0] m);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      tracker.mode = m;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(logic [MODE_W-1:0] m, int unsigned target, bit with_hold);
      int unsigned       sel;
      int unsigned       idx;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [SIZE_W-1:0] s;
      settle();
      write_mode(m);
      if (with_hold) begin
         @(posedge clock);
         hold_left = HOLD_CYCLES;
      end
      target += items_sent;
      while (items_sent < target) begin
         sel = $urandom_range(99);
         if (sel < 12) begin
            // reload the table, sometimes past full
            send_item(KIND_CLEAR, rand64(), $urandom);
            repeat ($urandom_range(RANGES + 2)) begin
               sel = $urandom_range(99);
               if (sel < 8)       a = '0;
               else if (sel < 16) a = ~64'd0 - $urandom_range(255);
               else if (sel < 60) a = {32'h0000_0001, 16'h0000, 16'($urandom)};
               else               a = rand64();
               sel = $urandom_range(99);
               if (sel < 8)       s = '0;
               else if (sel < 14) s = '1;
               else if (sel < 40) s = $urandom;
               else               s = $urandom_range(1, 4096);
               send_item(KIND_ADD, a, s);
            end
         end else if (sel < 18) begin
            send_item(KIND_FLUSH, rand64(), $urandom);
         end else if (sel < 24) begin
            send_item(kind_type'($urandom_range(3)), rand64(), $urandom);
         end else begin
            // event run: revisit recent addresses so class flips repeat
            repeat ($urandom_range(4, 24)) begin
               sel = $urandom_range(99);
               if (sel < 45) begin
                  a = addr_pool[$urandom_range(3)];
               end else begin
                  if (tracker.used != 0 && sel < 85) begin
                     idx = $urandom_range(tracker.used - 1);
                     lo  = tracker.range_lo[idx];
                     hi  = tracker.range_hi[idx];
                     case ($urandom_range(4))
                        0: a = lo;
                        1: a = hi;
                        2: a = lo - 1;
                        3: a = hi + 1;
                        default: a = (hi >= lo) ? lo + ({32'd0, $urandom} % (hi - lo + 1)) : lo;
                     endcase
                  end else begin
                     a = rand64();
                  end
                  addr_pool[$urandom_range(3)] = a;
               end
               send_item(KIND_EVENT, a, $urandom);
            end
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_EVENT;
      req_ch.address    = '0;
      req_ch.range_size = '0;
      rsp_ch.ready      = 1'b0;
      csr_write_enable  = 1'b0;
      csr_write_data    = MODE_RESET;
      req_idle_pct      = 8;
      rsp_idle_pct      = 61;
      hold_left         = 0;
      items_sent        = 0;
      cycle_count       = 0;
      foreach (addr_pool[i]) addr_pool[i] = '0;
      tracker = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset mode: every class change reported
      send_item(KIND_EVENT, 64'd0, '0);
      send_item(KIND_ADD, 64'd0, 32'h10);
      send_item(KIND_ADD, 64'h1000, 32'd0);
      send_item(KIND_ADD, 64'h1000, 32'h100);
      send_item(KIND_ADD, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF);   // end wraps
      send_item(KIND_EVENT, 64'h1000, '1);
      send_item(KIND_EVENT, 64'h1100, '0);                          // end inclusive
      send_item(KIND_EVENT, 64'h1101, '0);
      send_item(KIND_EVENT, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      for (int i = 0; i < RANGES - 2; i++)
         send_item(KIND_ADD, 64'h8000_0000_0000_0000 + 64'(i) * 64'h1_0000, 32'(i + 1));
      send_item(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);   // table full
      send_item(KIND_EVENT, 64'h8000_0000_0000_0000, '0);
      send_item(KIND_CLEAR, '0, '0);
      send_item(KIND_EVENT, 64'h8000_0000_0000_0000, '0);
      send_item(KIND_FLUSH, '0, '0);
      settle();

      // inbound coalescing: repeat bumps count, new address emits, flush drains
      write_mode(MODE_INBOUND);
      send_item(KIND_ADD, 64'h2000, 32'h10);
      send_item(KIND_EVENT, 64'h2000, '0);
      send_item(KIND_EVENT, 64'h3000, '0);
      send_item(KIND_EVENT, 64'h2000, '0);
      send_item(KIND_EVENT, 64'h0, '0);
      send_item(KIND_EVENT, 64'h2010, '0);
      send_item(KIND_FLUSH, '0, '0);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 2) begin
            req_idle_pct = 61;
            rsp_idle_pct = 8;
         end else if (p == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         run_phase(PHASE_MODE[p], PHASE_ITEMS, p == 1);
      end
      settle();

      if (tracker.error_count == 0 && tracker.record_queue.size() == 0) begin
         $display("address_range_transition_recorder_unit test passed");
      end else begin
         $display("address_range_transition_recorder_unit test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/arrt_pkg.sv
rtl/arrt_channels.sv
rtl/arrt_range_table.sv
rtl/address_range_transition_recorder_unit.sv
tb/sv/address_range_transition_recorder_unit_tb.sv
